[rtl/cdiff_pkg.sv]
// ----------------------------------------------------------------------------
// cdiff_pkg
// Shared types and constants for the eighth-order central difference block.
// ----------------------------------------------------------------------------
package cdiff_pkg;

    localparam int COEFF_BITS = 24;
    localparam int OUT_BITS   = 36;
    localparam int INDEX_BITS = 12;
    localparam int LEN_BITS   = 13;
    localparam int HALO       = 4;
    localparam int WIN        = 8;
    localparam int TAPS       = 4;

    typedef logic signed [COEFF_BITS-1:0] coeff_t;
    typedef coeff_t [TAPS-1:0]            coeff_set_t;

    // Reset weights: 4/5, -1/5, 4/105, -1/280 with 22 fraction bits
    localparam coeff_t COEFF_ONE_RST   = 24'sd3355443;
    localparam coeff_t COEFF_TWO_RST   = -24'sd838861;
    localparam coeff_t COEFF_THREE_RST = 24'sd159783;
    localparam coeff_t COEFF_FOUR_RST  = -24'sd14980;
    localparam logic [LEN_BITS-1:0] ROW_LENGTH_RST = 13'd64;

    typedef enum logic [2:0] {
        CFG_ROW_LENGTH  = 3'd0,
        CFG_COEFF_ONE   = 3'd1,
        CFG_COEFF_TWO   = 3'd2,
        CFG_COEFF_THREE = 3'd3,
        CFG_COEFF_FOUR  = 3'd4
    } cfg_reg_t;

    // Side information that travels with a result through the pipeline
    typedef struct packed {
        logic [INDEX_BITS-1:0] point_index;
        logic                  row_end;
    } meta_t;

endpackage

[rtl/central_difference_8th_order.sv]
// ----------------------------------------------------------------------------
// central_difference_8th_order
// Streamed nine-point antisymmetric stencil along grid rows.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle while the result stream is not
// stalled, set by the three-register pipeline (difference, product,
// sum/clamp) that advances whenever its next stage frees; a result beat
// reaches m_tdata once its sample has passed through all three registers.
// Reset: rst_n clears the window, row position, pipeline valids and restores
// row_length to 64 and the four weights to their eighth-order defaults.
// ----------------------------------------------------------------------------
module central_difference_8th_order #(
    parameter int SAMPLE_BITS     = 32,
    parameter int COEFF_FRAC_BITS = 22,
    parameter int MAX_ROW_LENGTH  = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [2:0]                              cfg_index,
    input  logic [cdiff_pkg::COEFF_BITS-1:0]        cfg_data,
    // sample stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    input  logic                                    s_tuser,  // row_start
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [47:0]                             m_tdata,  // derivative, point_index
    output logic                                    m_tlast   // row_end
);

    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int CAP       = MAX_ROW_LENGTH + 2 * cdiff_pkg::HALO;
    localparam int POS_W     = $clog2(CAP + 1);
    localparam int CMP_W     = ((POS_W > cdiff_pkg::LEN_BITS) ? POS_W
                                                              : cdiff_pkg::LEN_BITS) + 1;

    // Configuration registers
    logic [cdiff_pkg::LEN_BITS-1:0] row_length_reg;
    cdiff_pkg::coeff_set_t          coeff_reg;

    // Sample window: entry 0 is the oldest, f[-4] of the next centre point
    logic [SAMPLE_BITS-1:0]         win_reg [cdiff_pkg::WIN];
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               pos_next;

    // Difference stage
    logic                                           diff_vld_reg;
    logic [cdiff_pkg::TAPS-1:0][DIFF_W-1:0]         diff_reg;
    logic [cdiff_pkg::TAPS-1:0][DIFF_W-1:0]         diff_next;
    cdiff_pkg::meta_t                               meta_reg;
    cdiff_pkg::meta_t                               meta_next;

    logic                           accept;
    logic                           mac_ready;
    logic [SAMPLE_BITS-1:0]         sample;
    logic [CMP_W-1:0]               len_cmp;
    logic [CMP_W-1:0]               pos_cmp;
    logic [CMP_W-1:0]               idx_cmp;
    logic [POS_W-1:0]               pos_cur;
    logic                           hit;

    logic signed [cdiff_pkg::OUT_BITS-1:0] derivative;
    cdiff_pkg::meta_t                      out_meta;

    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = !diff_vld_reg || mac_ready;
    assign accept    = s_tvalid && s_tready;

    // Configuration: writes land at once; index beyond the register list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= cdiff_pkg::ROW_LENGTH_RST;
            coeff_reg[0]   <= cdiff_pkg::COEFF_ONE_RST;
            coeff_reg[1]   <= cdiff_pkg::COEFF_TWO_RST;
            coeff_reg[2]   <= cdiff_pkg::COEFF_THREE_RST;
            coeff_reg[3]   <= cdiff_pkg::COEFF_FOUR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cdiff_pkg::CFG_ROW_LENGTH:
                    row_length_reg <= cfg_data[cdiff_pkg::LEN_BITS-1:0];
                cdiff_pkg::CFG_COEFF_ONE:   coeff_reg[0] <= cfg_data;
                cdiff_pkg::CFG_COEFF_TWO:   coeff_reg[1] <= cfg_data;
                cdiff_pkg::CFG_COEFF_THREE: coeff_reg[2] <= cfg_data;
                cdiff_pkg::CFG_COEFF_FOUR:  coeff_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Row position and result decision for the incoming beat.
    // A result is due once eight samples of the row sit in the window and
    // the centre point is still interior; row_start restarts the count.
    always_comb
    begin
        pos_cur = s_tuser ? '0 : pos_reg;
        pos_cmp = CMP_W'(pos_cur);
        if (CMP_W'(row_length_reg) > CMP_W'(MAX_ROW_LENGTH))
        begin
            len_cmp = CMP_W'(MAX_ROW_LENGTH);
        end
        else
        begin
            len_cmp = CMP_W'(row_length_reg);
        end
        hit     = (pos_cmp >= CMP_W'(cdiff_pkg::WIN))
               && (pos_cmp < len_cmp + CMP_W'(cdiff_pkg::WIN));
        idx_cmp = pos_cmp - CMP_W'(cdiff_pkg::WIN);
        meta_next.point_index = idx_cmp[cdiff_pkg::INDEX_BITS-1:0];
        meta_next.row_end     = (pos_cmp == len_cmp + CMP_W'(cdiff_pkg::WIN - 1));
        // hold the count at its ceiling past the right halo
        if (pos_cmp < CMP_W'(CAP))
        begin
            pos_next = pos_cur + POS_W'(1);
        end
        else
        begin
            pos_next = pos_cur;
        end
    end

    // Differences of the mirrored pairs; the newest sample is f[+4]
    always_comb
    begin
        for (int k = 0; k < cdiff_pkg::TAPS - 1; k++)
        begin
            diff_next[k] = {win_reg[5 + k][SAMPLE_BITS-1], win_reg[5 + k]}
                         - {win_reg[3 - k][SAMPLE_BITS-1], win_reg[3 - k]};
        end
        diff_next[cdiff_pkg::TAPS-1] = {sample[SAMPLE_BITS-1], sample}
                                     - {win_reg[0][SAMPLE_BITS-1], win_reg[0]};
    end

    // Advance the window and position on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            diff_vld_reg <= 1'b0;
            for (int i = 0; i < cdiff_pkg::WIN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= pos_next;
                for (int i = 0; i < cdiff_pkg::WIN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[cdiff_pkg::WIN-1] <= sample;
                diff_vld_reg <= hit;
            end
            else if (mac_ready)
            begin
                diff_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            diff_reg <= diff_next;
            meta_reg <= meta_next;
        end
    end

    cdiff_mac #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_vld_reg),
        .in_ready  (mac_ready),
        .in_diff   (diff_reg),
        .in_meta   (meta_reg),
        .coeff     (coeff_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (derivative),
        .out_meta  (out_meta)
    );

    assign m_tdata = {out_meta.point_index, derivative};
    assign m_tlast = out_meta.row_end;

    // Position never runs past the end of the right halo of the longest row
    a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(pos_reg) <= CMP_W'(CAP))
        else $error("row position beyond its ceiling");

    // A new row's first beat leaves the count at one
    a_row_restart : assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser |=> pos_reg == POS_W'(1))
        else $error("row_start did not restart the position");

    // The difference stage fills only from an accepted beat
    a_diff_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(diff_vld_reg) |-> $past(accept))
        else $error("difference stage filled without a beat");

endmodule

[rtl/cdiff_mac.sv]
// ----------------------------------------------------------------------------
// cdiff_mac
// Weighted sum of four differences: product stage, then sum, shift and clamp.
// ----------------------------------------------------------------------------
module cdiff_mac #(
    parameter int SAMPLE_BITS     = 32,
    parameter int COEFF_FRAC_BITS = 22
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cdiff_pkg::TAPS-1:0][SAMPLE_BITS:0] in_diff,
    input  cdiff_pkg::meta_t                     in_meta,
    input  cdiff_pkg::coeff_set_t                coeff,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cdiff_pkg::OUT_BITS-1:0] out_value,
    output cdiff_pkg::meta_t                     out_meta
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + cdiff_pkg::COEFF_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int EXT_W  = (SUM_W > cdiff_pkg::OUT_BITS + 1) ? SUM_W
                                                              : cdiff_pkg::OUT_BITS + 1;

    localparam logic signed [EXT_W-1:0] OMAX =
        {{(EXT_W - cdiff_pkg::OUT_BITS + 1){1'b0}}, {(cdiff_pkg::OUT_BITS - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] OMIN =
        {{(EXT_W - cdiff_pkg::OUT_BITS + 1){1'b1}}, {(cdiff_pkg::OUT_BITS - 1){1'b0}}};

    logic                                       prod_vld_reg;
    logic [cdiff_pkg::TAPS-1:0][PROD_W-1:0]     prod_reg;
    logic [cdiff_pkg::TAPS-1:0][PROD_W-1:0]     prod_next;
    cdiff_pkg::meta_t                           prod_meta_reg;
    logic                                       out_vld_reg;
    logic signed [cdiff_pkg::OUT_BITS-1:0]      out_value_reg;
    cdiff_pkg::meta_t                           out_meta_reg;

    logic                                       out_free;
    logic                                       prod_take;
    logic                                       out_take;
    logic signed [EXT_W-1:0]                    sum_ext;
    logic signed [EXT_W-1:0]                    sum_sh;
    logic signed [cdiff_pkg::OUT_BITS-1:0]      out_value_next;

    assign out_free  = !out_vld_reg || out_ready;
    assign in_ready  = !prod_vld_reg || out_free;
    assign prod_take = in_valid && in_ready;
    assign out_take  = prod_vld_reg && out_free;

    always_comb
    begin
        for (int k = 0; k < cdiff_pkg::TAPS; k++)
        begin
            prod_next[k] = PROD_W'($signed(in_diff[k]) * $signed(coeff[k]));
        end
    end

    always_comb
    begin
        sum_ext = '0;
        for (int k = 0; k < cdiff_pkg::TAPS; k++)
        begin
            sum_ext = sum_ext + EXT_W'($signed(prod_reg[k]));
        end
        sum_sh = sum_ext >>> COEFF_FRAC_BITS;
        if (sum_sh > OMAX)
        begin
            out_value_next = OMAX[cdiff_pkg::OUT_BITS-1:0];
        end
        else if (sum_sh < OMIN)
        begin
            out_value_next = OMIN[cdiff_pkg::OUT_BITS-1:0];
        end
        else
        begin
            out_value_next = sum_sh[cdiff_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_vld_reg <= in_valid;
            end
            if (out_free)
            begin
                out_vld_reg <= prod_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_take)
        begin
            prod_reg      <= prod_next;
            prod_meta_reg <= in_meta;
        end
        if (out_take)
        begin
            out_value_reg <= out_value_next;
            out_meta_reg  <= prod_meta_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_value = out_value_reg;
    assign out_meta  = out_meta_reg;

    // A stalled result must not be overwritten by the product stage
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg)
        else $error("result dropped while stalled");

    // Every result comes from a product that was held the cycle before
    a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(prod_vld_reg))
        else $error("result appeared without a product");

    // Product stage only takes a new beat when it can pass on the old one
    a_prod_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
        prod_take && prod_vld_reg |-> out_take)
        else $error("product overwritten");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eighth-order central difference stencil.
// Streams grid rows into the sample port under several handshake regimes and
// compares every result beat against an in-bench model of the row window,
// the position counter and the fixed-point stencil sum.
// ----------------------------------------------------------------------------
module tb_top;

    import cdiff_pkg::*;

    localparam int SAMPLE_W     = 32;
    localparam int FRAC_BITS    = 22;
    localparam int MAX_LEN      = 4096;
    localparam int POS_CAP      = MAX_LEN + 2 * HALO;
    localparam int SETTLE       = 8;        // pipeline is three deep; leave margin
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 600;

    localparam longint DERIV_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint DERIV_MIN = -DERIV_MAX - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] derivative;
        logic [INDEX_BITS-1:0]      point_index;
        logic                       row_end;
    } deriv_beat_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [COEFF_BITS-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // sample
    logic                  s_tuser;   // row_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // derivative, point_index
    logic                  m_tlast;   // row_end

    always #2 clk = ~clk;

    central_difference_8th_order u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    int unsigned idle_pct  = 0;   // chance per beat that the sender holds off
    int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned samples_sent = 0;
    int unsigned results_checked = 0;
    int unsigned rows_sent = 0;

    // Model of the block: window of the last eight samples, row position,
    // row length and the four distance weights
    sample_t         sample_hist [WIN];
    logic [LEN_BITS-1:0] row_pos;
    logic [LEN_BITS-1:0] row_len_cfg;
    coeff_t          weights [TAPS];

    deriv_beat_t pending_derivs [$];

    // ------------------------------------------------------------------------
    // Stencil model: advance the window by one sample and queue the result
    // for the centre point whenever one falls due
    // ------------------------------------------------------------------------
    function automatic void predict_stencil(input sample_t x, input logic start);
        int unsigned len;
        int unsigned pos;
        int unsigned idx;
        longint      acc;
        longint      diff;
        deriv_beat_t beat;

        len = (row_len_cfg > MAX_LEN) ? MAX_LEN : row_len_cfg;
        if (start)
            row_pos = '0;
        pos = row_pos;

        if (pos >= WIN && pos < len + WIN)
        begin
            // hist[4-k] is f[-k]; hist[4+k] is f[+k] for k < 4; x is f[+4]
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                diff = longint'(sample_hist[5 + k]) - longint'(sample_hist[3 - k]);
                acc += diff * longint'(weights[k]);
            end
            diff = longint'(x) - longint'(sample_hist[0]);
            acc += diff * longint'(weights[3]);
            acc = acc >>> FRAC_BITS;
            if (acc > DERIV_MAX)
                acc = DERIV_MAX;
            else if (acc < DERIV_MIN)
                acc = DERIV_MIN;

            idx = pos - WIN;
            beat.derivative  = acc[OUT_BITS-1:0];
            beat.point_index = idx[INDEX_BITS-1:0];
            beat.row_end     = (idx + 1 == len);
            pending_derivs.push_back(beat);
        end

        for (int k = 0; k < WIN - 1; k++)
            sample_hist[k] = sample_hist[k + 1];
        sample_hist[WIN-1] = x;

        // Hold the position once the row has run past its right halo
        if (pos < POS_CAP)
            row_pos = pos + 1;
    endfunction

    // ------------------------------------------------------------------------
    // Sample beat: optional hold-off, then present the beat until accepted.
    // Valid is left high on return so back-to-back beats need no toggle.
    // ------------------------------------------------------------------------
    task automatic send_sample(input sample_t value, input logic start);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        predict_stencil(value, start);
        samples_sent++;
        if (start)
            rows_sent++;
    endtask

    // Drop valid and wait for every expected result, then let the pipeline
    // settle, since a beat with no result may still be in flight
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_derivs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [COEFF_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == CFG_ROW_LENGTH)
            row_len_cfg = value[LEN_BITS-1:0];
        else
            weights[int'(sel) - 1] = value;
        @(posedge clk);
    endtask

    task automatic program_all(input logic [LEN_BITS-1:0] len, input coeff_t w1,
                               input coeff_t w2, input coeff_t w3, input coeff_t w4);
        write_reg(CFG_ROW_LENGTH, {{(COEFF_BITS-LEN_BITS){1'b0}}, len});
        write_reg(CFG_COEFF_ONE, w1);
        write_reg(CFG_COEFF_TWO, w2);
        write_reg(CFG_COEFF_THREE, w3);
        write_reg(CFG_COEFF_FOUR, w4);
    endtask

    // Full-range sample with a bias towards the extremes and zero
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic coeff_t rand_weight();
        case ($urandom_range(0, 7))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            default: return coeff_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        deriv_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_derivs.size() == 0)
            begin
                $error("result beat with nothing expected: data %h last %b",
                       m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                exp_beat = pending_derivs.pop_front();
                results_checked++;
                if (m_tdata[OUT_BITS-1:0] !== exp_beat.derivative)
                begin
                    $error("derivative: expected %0d, got %0d", exp_beat.derivative,
                           $signed(m_tdata[OUT_BITS-1:0]));
                    error_count++;
                end
                if (m_tdata[OUT_BITS+INDEX_BITS-1:OUT_BITS] !== exp_beat.point_index)
                begin
                    $error("point_index: expected %0d, got %0d", exp_beat.point_index,
                           m_tdata[OUT_BITS+INDEX_BITS-1:OUT_BITS]);
                    error_count++;
                end
                if (m_tlast !== exp_beat.row_end)
                begin
                    $error("row_end: expected %b, got %b", exp_beat.row_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset weights and length; the first beat with no row start counts as
    // position zero
    task automatic test_reset_state();
        for (int k = 0; k < 20; k++)
            send_sample(rand_sample(), 1'b0);
        wait_drain();
    endtask

    // Extreme weights against extreme samples, then empty and single-point rows
    task automatic test_extremes();
        program_all(13'd2, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF);
        for (int k = 0; k < 10; k++)
            send_sample((k < 5) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, k == 0);
        wait_drain();
        program_all(13'd2, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000);
        for (int k = 0; k < 10; k++)
            send_sample((k < 5) ? 32'sh7FFF_FFFF : 32'sh8000_0000, k == 0);
        wait_drain();
        // an empty row yields nothing, even with samples trailing past it
        write_reg(CFG_ROW_LENGTH, 24'd0);
        for (int k = 0; k < 10; k++)
            send_sample(rand_sample(), k == 0);
        wait_drain();
        write_reg(CFG_ROW_LENGTH, 24'd1);
        for (int k = 0; k < 9; k++)
            send_sample(rand_sample(), k == 0);
        wait_drain();
    endtask

    // Longest legal length, then a length above the maximum that must clamp,
    // each over the first points of a row
    task automatic test_long_rows();
        program_all(13'd4096, rand_weight(), rand_weight(), rand_weight(), rand_weight());
        for (int k = 0; k < 24; k++)
            send_sample(rand_sample(), k == 0);
        wait_drain();
        write_reg(CFG_ROW_LENGTH, 24'd8191);
        for (int k = 0; k < 24; k++)
            send_sample(rand_sample(), k == 0);
        wait_drain();
    endtask

    // Mostly well-formed rows with random content; the rest truncated rows,
    // overrunning rows and stray row starts
    task automatic send_random_rows(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned total;
        int unsigned kind;
        logic        start;
        sent = 0;
        while (sent < n_items)
        begin
            len   = (row_len_cfg > MAX_LEN) ? MAX_LEN : row_len_cfg;
            total = len + 2 * HALO;
            kind  = $urandom_range(0, 9);
            if (kind == 0)
                total = $urandom_range(1, total);
            else if (kind == 1)
                total = total + $urandom_range(1, 6);
            for (int k = 0; k < total; k++)
            begin
                if (kind == 2)
                    start = ($urandom_range(0, 7) == 0);
                else
                    start = (k == 0);
                send_sample(rand_sample(), start);
            end
            sent += total;
        end
    endtask

    task automatic test_random(input int unsigned idle, input int unsigned stall,
                               input int unsigned n_items);
        logic [LEN_BITS-1:0] len;
        idle_pct  = idle;
        stall_pct = stall;
        for (int seg = 0; seg < 3; seg++)
        begin
            wait_drain();
            case ($urandom_range(0, 15))
                0:       len = '0;
                1:       len = LEN_BITS'($urandom_range(25, 200));
                default: len = LEN_BITS'($urandom_range(1, 24));
            endcase
            program_all(len, rand_weight(), rand_weight(), rand_weight(), rand_weight());
            send_random_rows(n_items / 3);
        end
        wait_drain();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        for (int k = 0; k < WIN; k++)
            sample_hist[k] = '0;
        row_pos     = '0;
        row_len_cfg = ROW_LENGTH_RST;
        weights[0]  = COEFF_ONE_RST;
        weights[1]  = COEFF_TWO_RST;
        weights[2]  = COEFF_THREE_RST;
        weights[3]  = COEFF_FOUR_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_extremes();
        test_long_rows();
        test_random(0, 0, RANDOM_ITEMS / 4);
        test_random(87, 0, RANDOM_ITEMS / 4);
        test_random(0, 87, RANDOM_ITEMS / 4);
        test_random(26, 26, RANDOM_ITEMS / 4);

        $display("tb_top: %0d samples in %0d started rows, %0d results compared",
                 samples_sent, rows_sent, results_checked);
        $display("tb_top: covered reset weights, extreme weights, empty, single-point,");
        $display("tb_top: longest and over-length rows under idle and stall phases");
        if (error_count == 0 && pending_derivs.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
